### hdl/three_sum_target_detector_top_assert.svh
// Assertion macros shared by the detector RTL.
`ifndef THREE_SUM_TARGET_DETECTOR_TOP_ASSERT_SVH
`define THREE_SUM_TARGET_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsd assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsd assertion failed");

`endif

### hdl/tsd_pkg.sv
`default_nettype none
package tsd_pkg;
   localparam int SAMPLE_BITS   = 32;
   localparam int TARGET_BITS   = 34;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;
   // Register index as decoded from paddr (8-byte register spacing).
   localparam logic REG_TARGET_SUM = 1'b0;
endpackage
`default_nettype wire

### hdl/tsd_req_if.sv
`default_nettype none
interface tsd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tsd_pkg::SAMPLE_BITS-1:0] sample_value;
   logic                                 last_item;

   modport source (output valid, output sample_value, output last_item, input ready);
   modport sink   (input valid, input sample_value, input last_item, output ready);
endinterface
`default_nettype wire

### hdl/tsd_rsp_if.sv
`default_nettype none
interface tsd_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic overflowed;

   modport source (output valid, output found, output overflowed, input ready);
   modport sink   (input valid, input found, input overflowed, output ready);
endinterface
`default_nettype wire

### hdl/tsd_ram.sv
`default_nettype none
module tsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hdl/three_sum_target_detector_top.sv
// Three-sum detector: values arrive one per transfer on req_chan and are written
// to a single-port-pair RAM at one per cycle (req ready stays high while loading).
// The transfer with last_item set ends the set; the block then drops ready,
// insertion-sorts the RAM in place and runs a two-pointer scan per anchor, and
// finally posts one transfer on rsp_chan with found and overflowed. Every sort and
// scan step is paced by the one RAM read port, whose registered data returns in the
// cycle after the address. Values beyond MAX_ITEMS are dropped and reported through
// overflowed. target_sum is a 34-bit signed register at address 0 of the 64-bit APB
// port; the scan compares full-precision sums.
`default_nettype none
`include "three_sum_target_detector_top_assert.svh"
module three_sum_target_detector_top #(
   parameter int MAX_ITEMS  = 1024,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tsd_req_if.sink                                  req_chan,
   tsd_rsp_if.source                                rsp_chan,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tsd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [tsd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [tsd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready
);
   localparam int AW    = $clog2(MAX_ITEMS);
   localparam int CW    = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = (VALUE_BITS + 2 > tsd_pkg::TARGET_BITS) ?
                          VALUE_BITS + 2 : tsd_pkg::TARGET_BITS;

   localparam logic [3:0] S_LOAD     = 4'd0;
   localparam logic [3:0] S_SORT_I   = 4'd1;
   localparam logic [3:0] S_SORT_KEY = 4'd2;
   localparam logic [3:0] S_SORT_CMP = 4'd3;
   localparam logic [3:0] S_SORT_PUT = 4'd4;
   localparam logic [3:0] S_SRCH_A   = 4'd5;
   localparam logic [3:0] S_SRCH_AV  = 4'd6;
   localparam logic [3:0] S_SRCH_LV  = 4'd7;
   localparam logic [3:0] S_SRCH_HV  = 4'd8;
   localparam logic [3:0] S_NEXT_LO  = 4'd9;
   localparam logic [3:0] S_SUM      = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0]                               state_ff, state_in;
   logic [CW-1:0]                            count_ff, count_in;
   logic                                     drop_ff, drop_in;
   logic [CW-1:0]                            i_ff, i_in;
   logic [AW-1:0]                            j_ff, j_in;
   logic signed [VALUE_BITS-1:0]             key_ff, key_in;
   logic [AW-1:0]                            a_ff, a_in;
   logic [AW-1:0]                            lo_ff, lo_in;
   logic [AW-1:0]                            hi_ff, hi_in;
   logic signed [VALUE_BITS-1:0]             a_val_ff, a_val_in;
   logic signed [VALUE_BITS-1:0]             l_val_ff, l_val_in;
   logic signed [VALUE_BITS-1:0]             h_val_ff, h_val_in;
   logic                                     found_ff, found_in;
   logic signed [tsd_pkg::TARGET_BITS-1:0]   target_ff, target_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     rsp_found_ff, rsp_found_in;
   logic                                     rsp_over_ff, rsp_over_in;

   logic                                     wr_en;
   logic [AW-1:0]                            wr_addr;
   logic [VALUE_BITS-1:0]                    wr_data;
   logic [AW-1:0]                            rd_addr;
   logic [VALUE_BITS-1:0]                    rd_data;

   logic [63:0]                              sample_wide;
   logic [VALUE_BITS-1:0]                    new_val;
   logic signed [SUM_W-1:0]                  sum;
   logic signed [SUM_W-1:0]                  target_wide;
   logic                                     req_fire;
   logic                                     csr_write;

   tsd_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sample_wide = {32'b0, req_chan.sample_value};
   assign new_val     = sample_wide[VALUE_BITS-1:0];
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign csr_write   = psel && penable && pwrite;
   assign target_wide = SUM_W'(target_ff);
   assign sum = SUM_W'(a_val_ff) + SUM_W'(l_val_ff) + SUM_W'(h_val_ff);

   assign req_chan.ready      = (state_ff == S_LOAD);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.overflowed = rsp_over_ff;
   assign pready              = 1'b1;
   assign prdata = (paddr[3] == tsd_pkg::REG_TARGET_SUM && paddr[2:0] == 3'd0) ?
                   tsd_pkg::CSR_DATA_BITS'(target_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_in       = key_ff;
      a_in         = a_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      a_val_in     = a_val_ff;
      l_val_in     = l_val_ff;
      h_val_in     = h_val_ff;
      found_in     = found_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_over_in  = rsp_over_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = new_val;
      rd_addr      = i_ff[AW-1:0];

      if (csr_write && paddr[3] == tsd_pkg::REG_TARGET_SUM) begin
         target_in = pwdata[tsd_pkg::TARGET_BITS-1:0];
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_chan.last_item) begin
                  i_in     = CW'(1);
                  state_in = S_SORT_I;
               end
            end
         end
         S_SORT_I: begin
            if (i_ff >= count_ff) begin
               a_in     = '0;
               state_in = S_SRCH_A;
            end else begin
               state_in = S_SORT_KEY;
            end
         end
         S_SORT_KEY: begin
            key_in   = rd_data;
            j_in     = i_ff[AW-1:0];
            rd_addr  = i_ff[AW-1:0] - 1'b1;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if ($signed(rd_data) > key_ff) begin
               // Shift the larger neighbor up one slot and keep walking down.
               wr_data = rd_data;
               j_in    = j_ff - 1'b1;
               rd_addr = j_ff - AW'(2);
               if (j_ff == AW'(1)) begin
                  state_in = S_SORT_PUT;
               end
            end else begin
               wr_data  = key_ff;
               i_in     = i_ff + 1'b1;
               state_in = S_SORT_I;
            end
         end
         S_SORT_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff;
            wr_data  = key_ff;
            i_in     = i_ff + 1'b1;
            state_in = S_SORT_I;
         end
         S_SRCH_A: begin
            if (({1'b0, a_ff} + (AW + 1)'(2)) >= (AW + 1)'(count_ff)
                || count_ff < CW'(3)) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               rd_addr  = a_ff;
               lo_in    = a_ff + 1'b1;
               hi_in    = count_ff[AW-1:0] - 1'b1;
               state_in = S_SRCH_AV;
            end
         end
         S_SRCH_AV: begin
            a_val_in = rd_data;
            rd_addr  = lo_ff;
            state_in = S_SRCH_LV;
         end
         S_SRCH_LV: begin
            l_val_in = rd_data;
            rd_addr  = hi_ff;
            state_in = S_SRCH_HV;
         end
         S_SRCH_HV: begin
            h_val_in = rd_data;
            state_in = S_SUM;
         end
         S_NEXT_LO: begin
            l_val_in = rd_data;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (hi_ff <= lo_ff) begin
               a_in     = a_ff + 1'b1;
               state_in = S_SRCH_A;
            end else if (sum == target_wide) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (sum > target_wide) begin
               hi_in    = hi_ff - 1'b1;
               rd_addr  = hi_ff - 1'b1;
               state_in = S_SRCH_HV;
            end else begin
               lo_in    = lo_ff + 1'b1;
               rd_addr  = lo_ff + 1'b1;
               state_in = S_NEXT_LO;
            end
         end
         S_DONE: begin
            // Wait until the output register is free before posting the result.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_over_in  = drop_ff;
               count_in     = '0;
               drop_in      = 1'b0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         a_ff         <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         a_ff         <= a_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      key_ff       <= key_in;
      a_val_ff     <= a_val_in;
      l_val_ff     <= l_val_in;
      h_val_ff     <= h_val_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_over_ff  <= rsp_over_in;
   end

   `TSD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_ITEMS))
   `TSD_ASSERT_IMP(a_sort_walk, clock, reset, state_ff == S_SORT_CMP,
                   CW'(j_ff) <= i_ff && j_ff != '0)
   `TSD_ASSERT_IMP(a_anchor_below, clock, reset, state_ff == S_SUM, a_ff < lo_ff)
   `TSD_ASSERT_NXT(a_hold_result, clock, reset,
                   state_ff == S_DONE && rsp_valid_ff && !rsp_chan.ready,
                   state_ff == S_DONE && rsp_valid_ff)
endmodule
`default_nettype wire

### sim/tb.sv
`default_nettype none
module tb;
   localparam int MAX_VALUES = 1024;
   localparam int CYCLE_LIMIT = 6000000;

   typedef struct {
      logic signed [tsd_pkg::SAMPLE_BITS-1:0] sample_value;
      logic                                   last_item;
   } sample_type;

   typedef struct {
      logic found;
      logic overflowed;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [tsd_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [tsd_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [tsd_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   tsd_req_if req_chan ();
   tsd_rsp_if rsp_chan ();

   three_sum_target_detector_top u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   sample_type  pending_samples[$];
   verdict_type expected_verdicts[$];
   longint      set_values[$];
   logic signed [tsd_pkg::TARGET_BITS-1:0] target_sum_model = '0;
   int errors = 0;
   int verdicts_seen = 0;
   int sets_sent = 0;
   longint cycle_count = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Sort the collected set and run the anchor/two-pointer search.
   function automatic logic three_sum_hits(longint vals[$], longint goal);
      longint sorted_vals[$];
      int lo, hi;
      longint s;
      sorted_vals = vals;
      sorted_vals.sort();
      for (int a = 0; a + 2 < sorted_vals.size(); a++) begin
         lo = a + 1;
         hi = sorted_vals.size() - 1;
         while (hi > lo) begin
            s = sorted_vals[a] + sorted_vals[lo] + sorted_vals[hi];
            if (s == goal) return 1'b1;
            if (s > goal) hi--;
            else lo++;
         end
      end
      return 1'b0;
   endfunction

   // Remember which transfers completed at this edge for the drivers.
   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      rsp_taken <= !reset && rsp_chan.valid && rsp_chan.ready;
   end

   // Track each transfer the block accepts and predict the verdict on the last one.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         set_values.push_back(longint'(req_chan.sample_value));
         if (req_chan.last_item) begin
            verdict_type v;
            longint kept[$];
            kept.delete();
            for (int i = 0; i < set_values.size() && i < MAX_VALUES; i++)
               kept.push_back(set_values[i]);
            v.found = three_sum_hits(kept, longint'(target_sum_model));
            v.overflowed = set_values.size() > MAX_VALUES;
            expected_verdicts.push_back(v);
            set_values.delete();
         end
      end
   end

   // Driver: one pending sample per transfer, with a random gap after each.
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.sample_value <= '0;
         req_chan.last_item <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         // The offered sample is still waiting for the block.
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_chan.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
         sample_type s;
         s = pending_samples.pop_front();
         req_chan.valid <= 1'b1;
         req_chan.sample_value <= s.sample_value;
         req_chan.last_item <= s.last_item;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Monitor: compare each verdict with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         verdicts_seen++;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict found=%b overflowed=%b", $time,
                     rsp_chan.found, rsp_chan.overflowed);
            errors++;
         end else begin
            verdict_type e;
            e = expected_verdicts.pop_front();
            if (e.found !== rsp_chan.found || e.overflowed !== rsp_chan.overflowed) begin
               $display({"%0t: verdict mismatch expected found=%b overflowed=%b,",
                         " actual found=%b overflowed=%b"},
                        $time, e.found, e.overflowed, rsp_chan.found,
                        rsp_chan.overflowed);
               errors++;
            end
         end
      end
   end

   // Result sink: after every transfer, wait a random number of cycles.
   int stall_left = 0;
   int stall_draw = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_taken) begin
         stall_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (stall_draw > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left <= stall_draw - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_target(input longint goal);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {tsd_pkg::REG_TARGET_SUM, 3'b000};
      pwdata <= tsd_pkg::CSR_DATA_BITS'(goal);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      target_sum_model = tsd_pkg::TARGET_BITS'(goal);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic queue_set(input longint vals[$]);
      sample_type s;
      foreach (vals[i]) begin
         s.sample_value = tsd_pkg::SAMPLE_BITS'(vals[i]);
         s.last_item = (i == vals.size() - 1);
         pending_samples.push_back(s);
      end
      sets_sent++;
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || req_chan.valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic longint rand_value(input int mode);
      case (mode)
         0: return longint'($urandom_range(0, 20)) - 10;
         1: return longint'(signed'($urandom()));
         default: return ($urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648)
                         - longint'($urandom_range(0, 2));
      endcase
   endfunction

   // Random sets of one to ten values each, drawn in the given mode, until the item budget is met.
   task automatic random_sets(input int item_budget, input int mode);
      longint vals[$];
      int n, sent;
      sent = 0;
      while (sent < item_budget) begin
         vals.delete();
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
         for (int i = 0; i < n; i++) vals.push_back(rand_value(mode));
         queue_set(vals);
         sent += n;
      end
   endtask

   initial begin
      longint vals[$];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: too few values, extremes, exact hits and misses.
      vals = '{5}; queue_set(vals);
      vals = '{1, 2}; queue_set(vals);
      vals = '{-1, 0, 1}; queue_set(vals);
      vals = '{3, -7, 9, 1}; queue_set(vals);
      vals = '{2147483647, 2147483647, 2147483647}; queue_set(vals);
      drain();
      write_target(64'sd6442450941);
      vals = '{2147483647, 2147483647, 2147483647, 0}; queue_set(vals);
      drain();
      write_target(-64'sd6442450944);
      vals = '{-2147483648, -2147483648, -2147483648}; queue_set(vals);
      vals = '{-2147483648, -2147483648, 5}; queue_set(vals);
      drain();
      // Store full: one set past capacity with its last two values dropped.
      write_target(3);
      vals.delete();
      for (int i = 0; i < MAX_VALUES + 2; i++) vals.push_back(i % 2);
      queue_set(vals);
      drain();

      write_target(0);
      random_sets(80, 0);
      drain();
      write_target(longint'($urandom_range(0, 10)) - 5);
      random_sets(60, 0);
      drain();
      write_target(longint'(signed'($urandom())) * 2);
      random_sets(40, 1);
      drain();
      write_target(-64'sd6442450944 + longint'($urandom_range(0, 3)));
      random_sets(40, 2);
      drain();

      $display("Ran %0d data sets including a full-store overflow, %0d verdicts checked.",
               sets_sent, verdicts_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire
